/* hw/rtl/pfba_pkg.sv */
// Shared codes for the page frame bitmap allocator.
// Holds command and status encodings; no dependencies.
`timescale 1ns / 1ps

package pfba_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_FREE    = 2'd1;
  localparam cmd_t CMD_RESERVE = 2'd2;

  localparam status_t STAT_DONE    = 2'd0;
  localparam status_t STAT_NO_FREE = 2'd1;
  localparam status_t STAT_RANGE   = 2'd2;

  localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;

endpackage

/* hw/rtl/page_frame_bitmap_allocator.sv */
// Next-fit page frame allocator over a used/free bitmap in a 32-bit word memory; uses pfba_pkg.
// Free/reserve: S_RMW writes back the read word (skipped when out of range); allocate: S_SCAN
// over w words (1 .. words in use), one word a cycle via the single memory read port, then S_DONE.
// One item at a time: in_ready returns as the result enters the output register, so the next
// item waits while the output register is held.
// Reset starts a clearing pass over all (MAX_FRAMES+31)/32 words, one a cycle, in_ready low.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_phys_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_frame_address,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_frame_count
);

  localparam int WORDS     = (MAX_FRAMES + 31) / 32;
  localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RST_LIVE  = (32768 > MAX_FRAMES) ? MAX_FRAMES : 32768;
  localparam int RST_WORDS = (RST_LIVE + 31) / 32;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [WW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [WW-1:0]   rover_r, rover_nxt;
  logic [WW-1:0]   cur_w_r, cur_w_nxt;
  logic [11:0]     scan_cnt_r, scan_cnt_nxt;
  logic [4:0]      bit_r, bit_nxt;
  logic            set_r, set_nxt;
  logic [15:0]     live_r;
  logic [11:0]     entries_r;
  logic [31:0]     res_addr_r, res_addr_nxt;
  pfba_pkg::status_t res_stat_r, res_stat_nxt;
  logic            out_valid_r;
  logic [31:0]     out_addr_r;
  pfba_pkg::status_t out_stat_r;

  logic [31:0]     mem [WORDS];
  logic [31:0]     rd_data_r;
  logic            mem_we;
  logic [WW-1:0]   mem_wa, mem_ra;
  logic [31:0]     mem_wd;

  logic [31:0]     req_frame;
  logic            req_in_range;
  logic [WW-1:0]   start_w, next_w;
  logic            last_word;
  logic [31:0]     avail;
  logic            found;
  logic [4:0]      found_bit;
  logic [WW+4:0]   found_frame;
  logic [63:0]     found_addr;
  logic            accept, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_status        = out_stat_r;

  assign req_frame    = in_phys_address >> PAGE_SHIFT;
  assign req_in_range = req_frame < 32'(live_r);
  assign start_w      = (32'(rover_r) < 32'(entries_r)) ? rover_r : '0;
  assign next_w       = (32'(cur_w_r) + 32'd1 >= 32'(entries_r)) ? '0 : cur_w_r + 1'b1;
  assign last_word    = (32'(cur_w_r) == 32'(entries_r) - 32'd1) && (live_r[4:0] != 5'd0);

  // Bits of frames at or above the live count are treated as used.
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      avail[j] = !rd_data_r[j] && !(last_word && (5'(j) >= live_r[4:0]));
    end
  end

  always_comb begin
    found_bit = '0;
    for (int j = 31; j >= 0; j--) begin
      if (avail[j]) begin
        found_bit = 5'(j);
      end
    end
  end

  assign found       = (avail != '0);
  assign found_frame = {cur_w_r, found_bit};
  assign found_addr  = 64'(found_frame) << PAGE_SHIFT;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    rover_nxt    = rover_r;
    cur_w_nxt    = cur_w_r;
    scan_cnt_nxt = scan_cnt_r;
    bit_nxt      = bit_r;
    set_nxt      = set_r;
    res_addr_nxt = res_addr_r;
    res_stat_nxt = res_stat_r;
    mem_we       = 1'b0;
    mem_wa       = cur_w_r;
    mem_wd       = rd_data_r;
    mem_ra       = cur_w_r;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == 32'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_addr_nxt = '0;
          res_stat_nxt = pfba_pkg::STAT_DONE;
          state_nxt    = S_DONE;
          if (in_command == pfba_pkg::CMD_ALLOC) begin
            res_stat_nxt = pfba_pkg::STAT_NO_FREE;
            if (entries_r != '0) begin
              mem_ra       = start_w;
              cur_w_nxt    = start_w;
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end else if (in_command == pfba_pkg::CMD_FREE ||
                       in_command == pfba_pkg::CMD_RESERVE) begin
            if (req_in_range) begin
              mem_ra    = req_frame[WW+4:5];
              cur_w_nxt = req_frame[WW+4:5];
              bit_nxt   = req_frame[4:0];
              set_nxt   = (in_command == pfba_pkg::CMD_RESERVE);
              state_nxt = S_RMW;
            end else begin
              res_stat_nxt = pfba_pkg::STAT_RANGE;
            end
          end
        end
      end
      S_RMW: begin
        mem_we        = 1'b1;
        mem_wd        = rd_data_r;
        mem_wd[bit_r] = set_r;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        if (found) begin
          mem_we            = 1'b1;
          mem_wd            = rd_data_r;
          mem_wd[found_bit] = 1'b1;
          rover_nxt         = cur_w_r;
          res_addr_nxt      = found_addr[31:0];
          res_stat_nxt      = pfba_pkg::STAT_DONE;
          state_nxt         = S_DONE;
        end else if (scan_cnt_r == entries_r - 12'd1) begin
          state_nxt = S_DONE;
        end else begin
          mem_ra       = next_w;
          cur_w_nxt    = next_w;
          scan_cnt_nxt = scan_cnt_r + 12'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      rover_r     <= '0;
      live_r      <= 16'(RST_LIVE);
      entries_r   <= 12'(RST_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rover_r   <= rover_nxt;
      if (cfg_valid && cfg_ready) begin
        if (32'(cfg_frame_count) > 32'(MAX_FRAMES)) begin
          live_r    <= 16'(RST_LIVE > MAX_FRAMES ? RST_LIVE : MAX_FRAMES);
          entries_r <= 12'((MAX_FRAMES + 31) / 32);
        end else begin
          live_r    <= cfg_frame_count;
          entries_r <= 12'((17'(cfg_frame_count) + 17'd31) >> 5);
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_w_r    <= cur_w_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    bit_r      <= bit_nxt;
    set_r      <= set_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    if (state_r == S_DONE && out_free) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

  // A new result only appears as the done state hands it over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the done state");

  // Only a successful allocation carries a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != pfba_pkg::STAT_DONE) |-> (out_addr_r == '0))
    else $error("failed request carries an address");

  // The rover moves only when a scan finds a free frame.
  a_rover_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(rover_r) |-> $past(state_r == S_SCAN && found))
    else $error("rover moved without an allocation");

  // A scan never examines more words than are in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r < entries_r))
    else $error("scan ran past the words in use");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the page frame bitmap allocator.
// Depends on pfba_pkg and page_frame_bitmap_allocator; predicts every result in-line.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_FRAMES = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam int WORDS = (MAX_FRAMES + 31) / 32;
  localparam pfba_pkg::cmd_t CMD_UNUSED = 2'd3;
  // Slowest legal run: every allocate scanning all words behind long output stalls,
  // plus the clearing pass and the long receiver hold, taken several times over.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    pfba_pkg::cmd_t command;
    logic [31:0]    phys_address;
  } request_t;

  typedef struct {
    logic [31:0]       frame_address;
    pfba_pkg::status_t status;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pfba_pkg::cmd_t    in_command = pfba_pkg::CMD_ALLOC;
  logic [31:0]       in_phys_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_frame_address;
  pfba_pkg::status_t out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_frame_count = '0;

  request_t pending_requests[$];
  result_t  expected_results[$];

  // Mirror of the allocator state.
  logic [31:0] frame_map [WORDS];
  int unsigned rover;
  logic [15:0] frame_count_shadow;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 79;
  logic        hold_start = 1'b0;
  logic        receiver_hold = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  page_frame_bitmap_allocator #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_phys_address(in_phys_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_address(out_frame_address),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_frame_count(cfg_frame_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned live_frames();
    return (frame_count_shadow > MAX_FRAMES) ? MAX_FRAMES : frame_count_shadow;
  endfunction

  function automatic void allocator_step(input pfba_pkg::cmd_t cmd, input logic [31:0] addr,
                                         output logic [31:0] result_addr,
                                         output pfba_pkg::status_t result_status);
    int unsigned live;
    int unsigned entries;
    int unsigned start;
    int unsigned w;
    int unsigned j;
    int unsigned k;
    int unsigned frame;
    logic [63:0] wide_addr;
    bit found;
    live = live_frames();
    entries = (live + 31) / 32;
    result_addr = '0;
    result_status = pfba_pkg::STAT_DONE;
    case (cmd)
      pfba_pkg::CMD_ALLOC: begin
        result_status = pfba_pkg::STAT_NO_FREE;
        found = 1'b0;
        start = (rover < entries) ? rover : 0;
        for (k = 0; k < entries && !found; k++) begin
          w = start + k;
          if (w >= entries) w -= entries;
          if (frame_map[w] == pfba_pkg::ALL_USED) continue;
          for (j = 0; j < 32 && !found; j++) begin
            frame = w * 32 + j;
            if (frame < live && !frame_map[w][j]) begin
              frame_map[w][j] = 1'b1;
              rover = w;
              wide_addr = 64'(frame) << PAGE_SHIFT;
              result_addr = wide_addr[31:0];
              result_status = pfba_pkg::STAT_DONE;
              found = 1'b1;
            end
          end
        end
      end
      pfba_pkg::CMD_FREE, pfba_pkg::CMD_RESERVE: begin
        frame = addr >> PAGE_SHIFT;
        if (frame < live) frame_map[frame / 32][frame % 32] = (cmd == pfba_pkg::CMD_RESERVE);
        else result_status = pfba_pkg::STAT_RANGE;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Driver: a new request goes out once the previous one has been transferred.
  always @(posedge clk) begin : request_driver
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        in_command <= req.command;
        in_phys_address <= req.phys_address;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !receiver_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : long_hold
    wait (hold_start);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // Monitor: checks each result transfer, then predicts for each request transfer.
  always @(posedge clk) begin : result_monitor
    result_t want;
    logic [31:0] next_addr;
    pfba_pkg::status_t next_status;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_frame_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_frame_address !== want.frame_address)
            report_mismatch("frame_address", out_frame_address, want.frame_address);
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
        end
      end
      if (in_valid && in_ready) begin
        allocator_step(in_command, in_phys_address, next_addr, next_status);
        want.frame_address = next_addr;
        want.status = next_status;
        expected_results.push_back(want);
      end
    end
  end

  task automatic queue_request(input pfba_pkg::cmd_t cmd, input logic [31:0] addr);
    request_t req;
    req.command = cmd;
    req.phys_address = addr;
    pending_requests.push_back(req);
  endtask

  // Every request yields a result, so an empty expectation queue means the block is idle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_frame_count <= value;
    do @(posedge clk); while (!cfg_ready);
    frame_count_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_address(input int unsigned live);
    int unsigned pick;
    logic [31:0] frame;
    pick = $urandom_range(0, 99);
    if (pick >= 85) return $urandom();
    if (live != 0 && pick < 70) frame = $urandom_range(0, live - 1);
    else frame = $urandom_range(live, live + 40);
    return (frame << PAGE_SHIFT) | $urandom_range(0, (1 << PAGE_SHIFT) - 1);
  endfunction

  // Mostly allocations and frees, so small counts run out and the rover moves on.
  task automatic random_phase(input logic [15:0] count, input int unsigned items);
    int unsigned n;
    int unsigned pick;
    write_frame_count(count);
    for (n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) queue_request(pfba_pkg::CMD_ALLOC, $urandom());
      else if (pick < 78) queue_request(pfba_pkg::CMD_FREE, pick_address(live_frames()));
      else if (pick < 95) queue_request(pfba_pkg::CMD_RESERVE, pick_address(live_frames()));
      else queue_request(CMD_UNUSED, $urandom());
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    for (i = 0; i < WORDS; i++) frame_map[i] = '0;
    rover = 0;
    frame_count_shadow = 16'd32768;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset count: frame zero, the last frame, out of range,
    // the unused command and an allocation skipping a reserved frame.
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    queue_request(pfba_pkg::CMD_FREE, 32'h0000_0FFF);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_RESERVE, 32'h0000_2ABC);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_RESERVE, 32'h07FF_F000);
    queue_request(pfba_pkg::CMD_FREE, 32'h07FF_FFFF);
    queue_request(pfba_pkg::CMD_RESERVE, 32'h0800_0000);
    queue_request(pfba_pkg::CMD_FREE, 32'hFFFF_FFFF);
    queue_request(CMD_UNUSED, 32'hFFFF_FFFF);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);

    // A count of zero refuses everything.
    write_frame_count(16'd0);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_FREE, 32'h0);
    queue_request(pfba_pkg::CMD_RESERVE, 32'h0);

    // A count above capacity behaves as full capacity.
    write_frame_count(16'hFFFF);
    queue_request(pfba_pkg::CMD_RESERVE, 32'h07FF_F000);
    queue_request(pfba_pkg::CMD_FREE, 32'h0800_0000);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);

    // A single frame that is already taken.
    write_frame_count(16'd1);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_FREE, 32'h0);
    queue_request(pfba_pkg::CMD_ALLOC, 32'h0);
    queue_request(pfba_pkg::CMD_FREE, 32'h0000_1000);

    random_phase(16'd64, 100);
    // Lowering the count strands the rover beyond the words in use.
    random_phase(16'd20, 70);

    wait_idle();
    send_idle_pct <= 79;
    recv_idle_pct <= 33;
    random_phase(16'd32768, 90);
    random_phase(16'd1, 50);

    wait_idle();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_start <= 1'b1;
    random_phase(16'd300, 110);
    random_phase(16'hFFFF, 70);
    random_phase(16'd33, 70);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pfba_pkg.sv
hw/rtl/page_frame_bitmap_allocator.sv
tb/sv/testbench.sv
